// ----- sv/sdr_pkg.sv -----
// ----------------------------------------------------------------------------
// sdr_pkg
// Shared widths, controller commands and helpers for the signed divider.
// ----------------------------------------------------------------------------
package sdr_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(DATA_WIDTH);

    // per-cycle commands from the controller to the datapath
    typedef struct packed {
        logic load;     // capture operands and set up the magnitudes
        logic step;     // one restoring-division step
        logic publish;  // sign fix-up into the output register
    } t_dp_cmd;

    function automatic logic [DATA_WIDTH-1:0] magnitude(input logic [DATA_WIDTH-1:0] v);
        magnitude = v[DATA_WIDTH-1] ? (~v + DATA_WIDTH'(1)) : v;
    endfunction

endpackage

// ----- sv/sdr_ctrl.sv -----
// ----------------------------------------------------------------------------
// sdr_ctrl
// Sequencer for the divider: accept, iterate one quotient bit per cycle,
// then fix the signs into the output register when it is free.
// ----------------------------------------------------------------------------
module sdr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    output logic            o_valid,
    input  logic            i_stall,
    output sdr_pkg::t_dp_cmd o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_FIX  = 2'd2;

    logic [1:0]               r_state, n_state;
    logic [sdr_pkg::CNT_W-1:0] r_count, n_count;
    logic                     r_out_valid, n_out_valid;
    logic                     out_free;

    // output register is free when empty or its beat leaves this cycle
    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_out_valid   = r_out_valid && i_stall;
        o_cmd.load    = 1'b0;
        o_cmd.step    = 1'b0;
        o_cmd.publish = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_count    = sdr_pkg::CNT_W'(sdr_pkg::DATA_WIDTH - 1);
                    n_state    = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.step = 1'b1;
                if (r_count == '0) begin
                    n_state = ST_FIX;
                end else begin
                    n_count = r_count - sdr_pkg::CNT_W'(1);
                end
            end
            ST_FIX: begin
                if (out_free) begin
                    o_cmd.publish = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_out_valid;

endmodule

// ----- sv/sdr_dp.sv -----
// ----------------------------------------------------------------------------
// sdr_dp
// Divider datapath: magnitude setup, restoring shift-subtract step,
// sign fix-up and the output register.
// ----------------------------------------------------------------------------
module sdr_dp (
    input  logic                                i_clk,
    input  sdr_pkg::t_dp_cmd                    i_cmd,
    input  logic signed [sdr_pkg::DATA_WIDTH-1:0] i_dividend,
    input  logic signed [sdr_pkg::DATA_WIDTH-1:0] i_divisor,
    output logic signed [sdr_pkg::DATA_WIDTH-1:0] o_quotient,
    output logic signed [sdr_pkg::DATA_WIDTH-1:0] o_rest,
    output logic                                o_zero_divisor,
    output logic                                o_overflowed
);

    localparam int W = sdr_pkg::DATA_WIDTH;

    logic [W-1:0] r_a;      // dividend magnitude, shifts out into the quotient
    logic [W-1:0] r_b;      // divisor magnitude
    logic [W-1:0] r_r;      // partial remainder
    logic         r_num_neg;
    logic         r_q_neg;
    logic         r_dz;
    logic         r_ov;
    logic [W-1:0] r_quot;
    logic [W-1:0] r_rest;
    logic         r_dz_out;
    logic         r_ov_out;

    logic [W:0]   shifted;
    logic [W:0]   diff;
    logic [W-1:0] q_fix;
    logic [W-1:0] r_fix;
    logic [W-1:0] most_neg;

    assign most_neg = {1'b1, {(W-1){1'b0}}};
    assign shifted  = {r_r, r_a[W-1]};
    assign diff     = shifted - {1'b0, r_b};

    assign q_fix = r_dz ? '0 : (r_q_neg   ? (~r_a + W'(1)) : r_a);
    assign r_fix = r_dz ? '0 : (r_num_neg ? (~r_r + W'(1)) : r_r);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a       <= sdr_pkg::magnitude(i_dividend);
            r_b       <= sdr_pkg::magnitude(i_divisor);
            r_r       <= '0;
            r_num_neg <= i_dividend[W-1];
            r_q_neg   <= i_dividend[W-1] ^ i_divisor[W-1];
            r_dz      <= (i_divisor == '0);
            r_ov      <= (i_dividend == most_neg) && (i_divisor == '1);
        end else if (i_cmd.step) begin
            // borrow set: trial subtraction failed, keep the shifted value
            if (diff[W]) begin
                r_r <= shifted[W-1:0];
                r_a <= {r_a[W-2:0], 1'b0};
            end else begin
                r_r <= diff[W-1:0];
                r_a <= {r_a[W-2:0], 1'b1};
            end
        end
        if (i_cmd.publish) begin
            r_quot   <= q_fix;
            r_rest   <= r_fix;
            r_dz_out <= r_dz;
            r_ov_out <= r_ov;
        end
    end

    assign o_quotient     = r_quot;
    assign o_rest         = r_rest;
    assign o_zero_divisor = r_dz_out;
    assign o_overflowed   = r_ov_out;

endmodule

// ----- sv/signed_divider_remainder_top.sv -----
// sequence: load, then W restoring steps of one quotient bit each, then the
// sign fix-up, which waits while a stalled result beat blocks it; a new item
// is accepted only after the fix-up of the last one
// the output register holds a finished result while the next item divides
// reset (synchronous, active low) clears the sequencer and the output valid
// ----------------------------------------------------------------------------
// signed_divider_remainder_top
// Signed divider giving the truncated quotient and the dividend-signed
// remainder, with divide-by-zero and overflow flags.
// ----------------------------------------------------------------------------
module signed_divider_remainder_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [sdr_pkg::DATA_WIDTH-1:0] i_dividend,
    input  logic signed [sdr_pkg::DATA_WIDTH-1:0] i_divisor,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [sdr_pkg::DATA_WIDTH-1:0] o_quotient,
    output logic signed [sdr_pkg::DATA_WIDTH-1:0] o_rest,
    output logic                                o_zero_divisor,
    output logic                                o_overflowed
);

    sdr_pkg::t_dp_cmd cmd;

    sdr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (cmd)
    );

    sdr_dp u_dp (
        .i_clk          (i_clk),
        .i_cmd          (cmd),
        .i_dividend     (i_dividend),
        .i_divisor      (i_divisor),
        .o_quotient     (o_quotient),
        .o_rest         (o_rest),
        .o_zero_divisor (o_zero_divisor),
        .o_overflowed   (o_overflowed)
    );

endmodule

// ----- sv/sdr_checker.sv -----
// ----------------------------------------------------------------------------
// sdr_checker
// Port-level checks for the signed divider, bound to the top level.
// ----------------------------------------------------------------------------
module sdr_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic [sdr_pkg::DATA_WIDTH-1:0] o_quotient,
    input logic [sdr_pkg::DATA_WIDTH-1:0] o_rest,
    input logic                          o_zero_divisor,
    input logic                          o_overflowed
);

    localparam int W = sdr_pkg::DATA_WIDTH;

    // a held result beat stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_quotient) && $stable(o_rest))
        else $error("result beat changed while stalled");

    // busy right after an accepted beat
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input not stalled while dividing");

    a_zero_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_zero_divisor |-> o_quotient == '0 && o_rest == '0 && !o_overflowed)
        else $error("zero divisor result not cleared");

    a_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_overflowed |->
            o_quotient == {1'b1, {(W-1){1'b0}}} && o_rest == '0)
        else $error("overflow result not wrapped");

endmodule

bind signed_divider_remainder_top sdr_checker u_sdr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_quotient     (o_quotient),
    .o_rest         (o_rest),
    .o_zero_divisor (o_zero_divisor),
    .o_overflowed   (o_overflowed)
);
